// ===== design/epdr_pkg.sv =====
// ----------------------------------------------------------------------------
// epdr_pkg
// Shared types and constants for the EEG packet deframer / reorder block.
// ----------------------------------------------------------------------------
package epdr_pkg;

    localparam int MAX_CHANNELS_DEF = 24;
    localparam int OUT_COUNT        = 24;
    localparam int HDR_LAST         = 6;   // index of the last header byte (type, length, packet number)
    localparam int PAY_WORDS_START  = 11;  // first channel word byte in sample payload
    localparam int MIN_SAMPLE_LEN   = 15;
    localparam int TOKEN_BYTES      = 5;

    localparam logic [7:0]  TYPE_SAMPLE = 8'd1;
    localparam logic [7:0]  TYPE_EVENT  = 8'd5;

    localparam logic [31:0] EV_CODE_A     = 32'd1;
    localparam logic [31:0] EV_CODE_START = 32'd2;
    localparam logic [31:0] EV_CODE_STOP  = 32'd3;
    localparam logic [31:0] EV_CODE_B     = 32'd9;
    localparam logic [31:0] EV_CODE_C     = 32'd10;

    localparam logic [39:0] SYNC_TOKEN_RST = 40'h40_5350_4545;
    localparam logic [30:0] MIN_TIME_RST   = 31'h3A83_126F;
    localparam logic [30:0] TIME_INF_MAG   = 31'h7F80_0000;

    localparam logic CFG_SYNC_TOKEN = 1'b0;
    localparam logic CFG_MIN_TIME   = 1'b1;

    typedef logic [1:0] mode_t;
    localparam mode_t MODE_INITIAL   = 2'd0;
    localparam mode_t MODE_PREPARED  = 2'd1;
    localparam mode_t MODE_RECEIVING = 2'd2;

    // Source word feeding each output position.
    function automatic int src_of_pos(input int p);
        int r;
        begin
            r = 0;
            unique case (p)
                0:  r = 10;  1:  r = 11;  2:  r = 18;  3:  r = 2;
                4:  r = 3;   5:  r = 4;   6:  r = 19;  7:  r = 9;
                8:  r = 12;  9:  r = 1;   10: r = 7;   11: r = 5;
                12: r = 23;  13: r = 21;  14: r = 13;  15: r = 0;
                16: r = 6;   17: r = 22;  18: r = 14;  19: r = 15;
                20: r = 8;   21: r = 20;  22: r = 17;  23: r = 16;
                default: r = 0;
            endcase
            return r;
        end
    endfunction

    // One unit of work handed from the parser to the emitter.
    typedef struct packed {
        logic                          is_event;
        logic                          first;
        logic [31:0]                   code;
        logic [31:0]                   trig;
        logic [31:0]                   time_w;
        logic [47:0]                   adc;
        logic [OUT_COUNT-1:0][31:0]    samples;  // already in output order
    } job_t;

endpackage

// ===== design/eeg_packet_deframer_reorder_top.sv =====
// ----------------------------------------------------------------------------
// eeg_packet_deframer_reorder_top
// Byte-stream EEG packet deframer with reordered channel output.
// ----------------------------------------------------------------------------
// Takes one stream byte per beat and never stalls mid-packet: the parser
// consumes a byte every cycle. A valid sample packet produces 24 result
// beats (one per output channel, in the fixed reordered sequence) and an
// accepted event packet produces one; these leave through the emitter at one
// beat per cycle when not stalled, while the parser reads the next packet.
// A finished packet's results are parked in a one-job hand-off register;
// the input is stalled only on the last byte of a packet while the previous
// packet's job still waits there, so the byte rate drops below one per cycle
// only when results drain more slowly than packets arrive: short packets
// behind long result bursts, or a receiver that holds off. Configuration
// (index 0: sync token, index 1: minimum timestamp bits) is always ready and
// must be written while the block is idle. Results pass through the job
// register, the emitter's work register and its output register.
// ----------------------------------------------------------------------------
module eeg_packet_deframer_reorder_top #(
    parameter int MAX_CHANNELS = epdr_pkg::MAX_CHANNELS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // byte input
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  byte_in,
    // results
    output logic        out_valid,
    input  logic        out_stall,
    output logic        kind,
    output logic [4:0]  channel,
    output logic [31:0] sample_bits,
    output logic [31:0] trigger_bits,
    output logic [31:0] time_bits,
    output logic [47:0] adc_status,
    output logic        first_after_start,
    output logic [31:0] evt_code,
    output logic        last,
    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [39:0] cfg_data
);

    logic [39:0]    sync_token_reg;
    logic [30:0]    min_time_reg;
    epdr_pkg::job_t job;
    logic           job_valid;
    logic           job_take;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_token_reg <= epdr_pkg::SYNC_TOKEN_RST;
            min_time_reg   <= epdr_pkg::MIN_TIME_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                epdr_pkg::CFG_SYNC_TOKEN: sync_token_reg <= cfg_data;
                epdr_pkg::CFG_MIN_TIME:   min_time_reg   <= cfg_data[30:0];
                default: ;
            endcase
        end
    end

    // front: token search, header and payload capture
    epdr_front #(
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .byte_in       (byte_in),
        .sync_token    (sync_token_reg),
        .min_time_bits (min_time_reg),
        .job           (job),
        .job_valid     (job_valid),
        .job_take      (job_take)
    );

    // back: result burst out of the registered output stage
    epdr_back u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .job               (job),
        .job_valid         (job_valid),
        .job_take          (job_take),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .kind              (kind),
        .channel           (channel),
        .sample_bits       (sample_bits),
        .trigger_bits      (trigger_bits),
        .time_bits         (time_bits),
        .adc_status        (adc_status),
        .first_after_start (first_after_start),
        .evt_code          (evt_code),
        .last              (last)
    );

endmodule

// ===== design/epdr_front.sv =====
// ----------------------------------------------------------------------------
// epdr_front
// Byte parser: token search, header, payload capture, job register.
// ----------------------------------------------------------------------------
module epdr_front #(
    parameter int MAX_CHANNELS = epdr_pkg::MAX_CHANNELS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         byte_in,
    input  logic [39:0]        sync_token,
    input  logic [30:0]        min_time_bits,
    output epdr_pkg::job_t     job,
    output logic               job_valid,
    input  logic               job_take
);

    localparam int IW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int OUT_COUNT_W = epdr_pkg::OUT_COUNT;

    typedef enum logic [1:0] {PH_SEARCH, PH_HEADER, PH_PAYLOAD} phase_t;

    phase_t         phase_reg, phase_next;
    logic [39:0]    win_reg, win_next;
    logic [2:0]     wcnt_reg, wcnt_next;
    logic [15:0]    cnt_reg, cnt_next;
    logic [7:0]     type_reg, type_next;
    logic [15:0]    len_reg, len_next;
    logic [31:0]    time_reg, time_next;
    logic [47:0]    stat_reg, stat_next;
    logic [31:0]    wa_reg, wa_next;
    logic [31:0]    lastw_reg, lastw_next;
    epdr_pkg::mode_t mode_reg, mode_next;
    epdr_pkg::job_t job_reg, job_next;
    logic           job_valid_reg, job_valid_next;

    logic [31:0]    store [MAX_CHANNELS];
    logic           st_we;
    logic [15:0]    st_w;

    logic           accept;
    logic           finishing;
    logic [15:0]    cnt_inc;
    logic [15:0]    poff;
    logic           len_ok;
    logic           time_ok;
    logic [15:0]    nch_len;
    logic [OUT_COUNT_W-1:0][31:0] samp;

    assign cnt_inc   = cnt_reg + 16'd1;
    assign finishing = (phase_reg == PH_PAYLOAD) && (cnt_inc >= len_reg);
    assign in_stall  = job_valid_reg && finishing;
    assign accept    = in_valid && !in_stall;
    assign poff      = cnt_reg - 16'(epdr_pkg::PAY_WORDS_START);
    assign len_ok    = (len_reg >= 16'(epdr_pkg::MIN_SAMPLE_LEN))
                     && ((len_reg[1:0] - 2'd3) == 2'd0);
    assign time_ok   = !time_reg[31] && (time_reg[30:0] < epdr_pkg::TIME_INF_MAG)
                     && (time_reg[30:0] >= min_time_bits);

    // nch from the length field, not the byte position
    assign nch_len = ((len_reg - 16'(epdr_pkg::PAY_WORDS_START)) >> 2) - 16'd1;

    genvar gp;
    generate
        for (gp = 0; gp < OUT_COUNT_W; gp++) begin : g_pos
            localparam int S = epdr_pkg::src_of_pos(gp);
            if (S < MAX_CHANNELS) begin : g_src
                assign samp[gp] = ((16'(gp) < nch_len) && (16'(S) < nch_len))
                                ? store[S] : 32'd0;
            end else begin : g_none
                assign samp[gp] = 32'd0;
            end
        end
    endgenerate

    always_comb
    begin
        phase_next     = phase_reg;
        win_next       = win_reg;
        wcnt_next      = wcnt_reg;
        cnt_next       = cnt_reg;
        type_next      = type_reg;
        len_next       = len_reg;
        time_next      = time_reg;
        stat_next      = stat_reg;
        wa_next        = wa_reg;
        lastw_next     = lastw_reg;
        mode_next      = mode_reg;
        job_next       = job_reg;
        job_valid_next = job_valid_reg && !job_take;
        st_we          = 1'b0;
        st_w           = poff >> 2;
        if (accept)
        begin
            unique case (phase_reg)
                PH_SEARCH:
                begin
                    win_next = {win_reg[31:0], byte_in};
                    if (wcnt_reg < 3'(epdr_pkg::TOKEN_BYTES))
                    begin
                        wcnt_next = wcnt_reg + 3'd1;
                    end
                    if ((wcnt_next == 3'(epdr_pkg::TOKEN_BYTES))
                        && (win_next == sync_token))
                    begin
                        phase_next = PH_HEADER;
                        cnt_next   = 16'd0;
                    end
                end
                PH_HEADER:
                begin
                    if (cnt_reg == 16'd0) type_next = byte_in;
                    if (cnt_reg == 16'd1) len_next = {byte_in, 8'd0};
                    if (cnt_reg == 16'd2) len_next = {len_reg[15:8], byte_in};
                    if (cnt_reg >= 16'(epdr_pkg::HDR_LAST))
                    begin
                        time_next  = 32'd0;
                        stat_next  = 48'd0;
                        wa_next    = 32'd0;
                        lastw_next = 32'd0;
                        cnt_next   = 16'd0;
                        if (len_reg == 16'd0)
                        begin
                            // empty payload: nothing can be emitted
                            phase_next = PH_SEARCH;
                            win_next   = 40'd0;
                            wcnt_next  = 3'd0;
                        end
                        else
                        begin
                            phase_next = PH_PAYLOAD;
                        end
                    end
                    else
                    begin
                        cnt_next = cnt_inc;
                    end
                end
                PH_PAYLOAD:
                begin
                    if (type_reg == epdr_pkg::TYPE_SAMPLE)
                    begin
                        if (cnt_reg < 16'd4)
                        begin
                            time_next = {time_reg[23:0], byte_in};
                        end
                        else if (cnt_reg >= 16'd5 && cnt_reg < 16'd11)
                        begin
                            stat_next = {stat_reg[39:0], byte_in};
                        end
                        else if (cnt_reg >= 16'd11)
                        begin
                            wa_next = {wa_reg[23:0], byte_in};
                            if (poff[1:0] == 2'd3)
                            begin
                                lastw_next = wa_next;
                                st_we      = (st_w < 16'(MAX_CHANNELS));
                            end
                        end
                    end
                    else if ((type_reg == epdr_pkg::TYPE_EVENT) && (cnt_reg < 16'd4))
                    begin
                        wa_next = {wa_reg[23:0], byte_in};
                    end
                    cnt_next = cnt_inc;
                    if (finishing)
                    begin
                        phase_next = PH_SEARCH;
                        cnt_next   = 16'd0;
                        win_next   = 40'd0;
                        wcnt_next  = 3'd0;
                        job_next.is_event = 1'b0;
                        job_next.first    = 1'b0;
                        job_next.code     = 32'd0;
                        job_next.trig     = lastw_next;
                        job_next.time_w   = time_reg;
                        job_next.adc      = stat_reg;
                        job_next.samples  = samp;
                        if (type_reg == epdr_pkg::TYPE_SAMPLE)
                        begin
                            if (len_ok && time_ok)
                            begin
                                job_valid_next = 1'b1;
                                if (mode_reg == epdr_pkg::MODE_PREPARED)
                                begin
                                    mode_next      = epdr_pkg::MODE_RECEIVING;
                                    job_next.first = 1'b1;
                                end
                            end
                        end
                        else if ((type_reg == epdr_pkg::TYPE_EVENT) && (len_reg >= 16'd4))
                        begin
                            job_next.trig    = 32'd0;
                            job_next.time_w  = 32'd0;
                            job_next.adc     = 48'd0;
                            job_next.samples = '0;
                            job_next.is_event = 1'b1;
                            job_next.code    = wa_next;
                            if (wa_next == epdr_pkg::EV_CODE_A
                                || wa_next == epdr_pkg::EV_CODE_START
                                || wa_next == epdr_pkg::EV_CODE_STOP
                                || wa_next == epdr_pkg::EV_CODE_B
                                || wa_next == epdr_pkg::EV_CODE_C)
                            begin
                                job_valid_next = 1'b1;
                            end
                            if (wa_next == epdr_pkg::EV_CODE_START)
                                mode_next = epdr_pkg::MODE_PREPARED;
                            if (wa_next == epdr_pkg::EV_CODE_STOP)
                                mode_next = epdr_pkg::MODE_INITIAL;
                        end
                    end
                end
                default:
                begin
                    phase_next = PH_SEARCH;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_SEARCH;
            win_reg       <= 40'd0;
            wcnt_reg      <= 3'd0;
            cnt_reg       <= 16'd0;
            type_reg      <= 8'd0;
            len_reg       <= 16'd0;
            time_reg      <= 32'd0;
            stat_reg      <= 48'd0;
            wa_reg        <= 32'd0;
            lastw_reg     <= 32'd0;
            mode_reg      <= epdr_pkg::MODE_INITIAL;
            job_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            win_reg       <= win_next;
            wcnt_reg      <= wcnt_next;
            cnt_reg       <= cnt_next;
            type_reg      <= type_next;
            len_reg       <= len_next;
            time_reg      <= time_next;
            stat_reg      <= stat_next;
            wa_reg        <= wa_next;
            lastw_reg     <= lastw_next;
            mode_reg      <= mode_next;
            job_valid_reg <= job_valid_next;
        end
    end

    // payload only, no reset
    always_ff @(posedge clk)
    begin
        job_reg <= job_next;
        if (st_we)
        begin
            store[st_w[IW-1:0]] <= wa_next;
        end
    end

    assign job       = job_reg;
    assign job_valid = job_valid_reg;

endmodule

// ===== design/epdr_back.sv =====
// ----------------------------------------------------------------------------
// epdr_back
// Result emitter: walks one job out as result beats through an output register.
// ----------------------------------------------------------------------------
module epdr_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  epdr_pkg::job_t         job,
    input  logic                   job_valid,
    output logic                   job_take,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic                   kind,
    output logic [4:0]             channel,
    output logic [31:0]            sample_bits,
    output logic [31:0]            trigger_bits,
    output logic [31:0]            time_bits,
    output logic [47:0]            adc_status,
    output logic                   first_after_start,
    output logic [31:0]            evt_code,
    output logic                   last
);

    localparam logic [4:0] POS_LAST = 5'(epdr_pkg::OUT_COUNT - 1);

    epdr_pkg::job_t work_reg;
    logic           busy_reg;
    logic [4:0]     pos_reg;
    logic           valid_reg;
    logic           advance;
    logic           beat_last;

    assign job_take  = !busy_reg && job_valid;
    assign advance   = !valid_reg || !out_stall;
    assign beat_last = work_reg.is_event || (pos_reg == POS_LAST);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            pos_reg   <= 5'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                valid_reg <= busy_reg;
                if (busy_reg)
                begin
                    pos_reg <= pos_reg + 5'd1;
                    if (beat_last)
                        busy_reg <= 1'b0;
                end
            end
            if (job_take)
            begin
                busy_reg <= 1'b1;
                pos_reg  <= 5'd0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (job_take)
        begin
            work_reg <= job;
        end
        else if (advance && busy_reg)
        begin
            work_reg.samples <= {32'd0, work_reg.samples[epdr_pkg::OUT_COUNT-1:1]};
        end
        if (advance && busy_reg)
        begin
            kind              <= work_reg.is_event;
            channel           <= work_reg.is_event ? 5'd0 : pos_reg;
            sample_bits       <= work_reg.samples[0];
            trigger_bits      <= work_reg.trig;
            time_bits         <= work_reg.time_w;
            adc_status        <= work_reg.adc;
            first_after_start <= work_reg.first;
            evt_code          <= work_reg.code;
            last              <= beat_last;
        end
    end

    assign out_valid = valid_reg;

endmodule

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Testbench for the EEG packet deframer: builds packets as byte streams,
// predicts the reordered channel and event results, and checks every beat.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic        kind;
        logic [4:0]  channel;
        logic [31:0] sample_bits;
        logic [31:0] trigger_bits;
        logic [31:0] time_bits;
        logic [47:0] adc_status;
        logic        first_after_start;
        logic [31:0] evt_code;
        logic        last;
    } beat_t;

    // Predictor phases.
    localparam logic [1:0] PH_HUNT = 2'd0;
    localparam logic [1:0] PH_HDR  = 2'd1;
    localparam logic [1:0] PH_PAY  = 2'd2;

    // Source word per output position, as the block's channel map defines it.
    localparam int REORDER_MAP [24] = '{10, 11, 18, 2, 3, 4, 19, 9, 12, 1, 7, 5,
                                        23, 21, 13, 0, 6, 22, 14, 15, 8, 20, 17, 16};

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  byte_in;
    logic        out_valid;
    logic        out_stall;
    logic        kind;
    logic [4:0]  channel;
    logic [31:0] sample_bits;
    logic [31:0] trigger_bits;
    logic [31:0] time_bits;
    logic [47:0] adc_status;
    logic        first_after_start;
    logic [31:0] evt_code;
    logic        last;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [39:0] cfg_data;

    eeg_packet_deframer_reorder_top uut (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ---------------- predictor state ----------------
    logic [39:0] tok_reg;
    logic [30:0] min_time_reg;
    logic [39:0] win;
    logic [1:0]  phase;
    int unsigned cnt;
    logic [7:0]  ptype;
    logic [15:0] plen;
    logic [31:0] ts_word;
    logic [47:0] status_w;
    logic [31:0] asm_word;
    logic [31:0] chan_words [24];
    logic [31:0] trig_word;
    epdr_pkg::mode_t mode;

    beat_t       expected_beats [$];
    int          error_count;
    int          cycle_count;
    int          hold_off_cycles;   // long receiver hold-off, counted below
    bit          stall_random_on;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] exp_v);
        $display("MISMATCH %s: got %h expected %h (cycle %0d)", what, got, exp_v,
                 cycle_count);
        error_count++;
    endtask

    function automatic bit time_ok(input logic [31:0] t);
        if (t[31]) return 0;
        if (t[30:0] >= epdr_pkg::TIME_INF_MAG) return 0;
        return t[30:0] >= min_time_reg;
    endfunction

    // Results produced when a packet's final byte is consumed.
    task automatic close_packet();
        beat_t b;
        int unsigned nch;
        logic first;
        if (ptype == epdr_pkg::TYPE_SAMPLE)
        begin
            if (plen >= epdr_pkg::MIN_SAMPLE_LEN && ((plen - 11) % 4) == 0
                && time_ok(ts_word))
            begin
                nch = (plen - 11) / 4 - 1;
                first = 1'b0;
                if (mode == epdr_pkg::MODE_PREPARED)
                begin
                    mode = epdr_pkg::MODE_RECEIVING;
                    first = 1'b1;
                end
                for (int p = 0; p < epdr_pkg::OUT_COUNT; p++)
                begin
                    b = '0;
                    b.channel = 5'(p);
                    if (p < nch && REORDER_MAP[p] < nch)
                        b.sample_bits = chan_words[REORDER_MAP[p]];
                    b.trigger_bits = trig_word;
                    b.time_bits = ts_word;
                    b.adc_status = status_w;
                    b.first_after_start = first;
                    b.last = (p == epdr_pkg::OUT_COUNT - 1);
                    expected_beats.push_back(b);
                end
            end
        end
        else if (ptype == epdr_pkg::TYPE_EVENT && plen >= 4)
        begin
            if (asm_word == epdr_pkg::EV_CODE_A || asm_word == epdr_pkg::EV_CODE_START ||
                asm_word == epdr_pkg::EV_CODE_STOP || asm_word == epdr_pkg::EV_CODE_B ||
                asm_word == epdr_pkg::EV_CODE_C)
            begin
                if (asm_word == epdr_pkg::EV_CODE_START) mode = epdr_pkg::MODE_PREPARED;
                if (asm_word == epdr_pkg::EV_CODE_STOP) mode = epdr_pkg::MODE_INITIAL;
                b = '0;
                b.kind = 1'b1;
                b.evt_code = asm_word;
                b.last = 1'b1;
                expected_beats.push_back(b);
            end
        end
        phase = PH_HUNT;
        cnt = 0;
        win = '0;
    endtask

    task automatic predict_byte(input logic [7:0] v);
        int unsigned p;
        if (phase == PH_HUNT)
        begin
            win = {win[31:0], v};
            if (cnt < 5) cnt++;
            if (cnt >= 5 && win == tok_reg)
            begin
                phase = PH_HDR;
                cnt = 0;
            end
        end
        else if (phase == PH_HDR)
        begin
            if (cnt == 0) ptype = v;
            else if (cnt == 1) plen = {v, 8'h00};
            else if (cnt == 2) plen[7:0] = v;
            if (cnt >= epdr_pkg::HDR_LAST)
            begin
                ts_word = '0;
                status_w = '0;
                asm_word = '0;
                trig_word = '0;
                cnt = 0;
                if (plen == 0) close_packet();
                else phase = PH_PAY;
            end
            else
                cnt++;
        end
        else
        begin
            p = cnt;
            if (ptype == epdr_pkg::TYPE_SAMPLE)
            begin
                if (p < 4) ts_word = {ts_word[23:0], v};
                else if (p >= 5 && p < 11) status_w = {status_w[39:0], v};
                else if (p >= epdr_pkg::PAY_WORDS_START)
                begin
                    asm_word = {asm_word[23:0], v};
                    if (((p - 11) % 4) == 3)
                    begin
                        if ((p - 11) / 4 < 24) chan_words[(p - 11) / 4] = asm_word;
                        trig_word = asm_word;
                    end
                end
            end
            else if (ptype == epdr_pkg::TYPE_EVENT && p < 4)
                asm_word = {asm_word[23:0], v};
            cnt = (cnt + 1) & 16'hFFFF;
            if (cnt >= plen) close_packet();
        end
    endtask

    // ---------------- driving ----------------
    task automatic random_gap();
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) :
            ($urandom_range(0, 2) == 0 ? $urandom_range(1, 2) : 0);
        if (n > 0)
        begin
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic send_byte(input logic [7:0] v, input bit gaps);
        if (gaps) random_gap();
        in_valid <= 1'b1;
        byte_in <= v;
        do @(posedge clk); while (in_stall);
        predict_byte(v);
    endtask

    task automatic go_idle();
        in_valid <= 1'b0;
        while (expected_beats.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [39:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == epdr_pkg::CFG_SYNC_TOKEN) tok_reg = val;
        else min_time_reg = val[30:0];
    endtask

    task automatic send_token(input bit gaps);
        for (int i = 4; i >= 0; i--) send_byte(tok_reg[i*8 +: 8], gaps);
    endtask

    // Header after token: type, length, 4 ignored packet-number bytes.
    task automatic send_header(input logic [7:0] t, input logic [15:0] len, input bit gaps);
        send_token(gaps);
        send_byte(t, gaps);
        send_byte(len[15:8], gaps);
        send_byte(len[7:0], gaps);
        repeat (4) send_byte(8'($urandom), gaps);
    endtask

    // Sample packet with nwords trailing words (channels + trigger).
    task automatic send_sample(input int nwords, input logic [31:0] ts, input bit gaps);
        logic [31:0] w;
        send_header(epdr_pkg::TYPE_SAMPLE, 16'(11 + 4 * nwords), gaps);
        for (int i = 3; i >= 0; i--) send_byte(ts[i*8 +: 8], gaps);
        repeat (7) send_byte(8'($urandom), gaps);
        for (int k = 0; k < nwords; k++)
        begin
            w = $urandom;
            for (int i = 3; i >= 0; i--) send_byte(w[i*8 +: 8], gaps);
        end
    endtask

    task automatic send_event(input logic [31:0] code, input int extra, input bit gaps);
        send_header(epdr_pkg::TYPE_EVENT, 16'(4 + extra), gaps);
        for (int i = 3; i >= 0; i--) send_byte(code[i*8 +: 8], gaps);
        repeat (extra) send_byte(8'($urandom), gaps);
    endtask

    function automatic logic [31:0] good_time();
        logic [31:0] t;
        t = $urandom_range(32'h3A83_1270, 32'h7F7F_FFFF);
        return t;
    endfunction

    // ---------------- result checking ----------------
    always @(posedge clk)
    begin
        beat_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_beats.size() == 0)
            begin
                report_mismatch("unexpected beat", 64'(channel), 64'd0);
            end
            else
            begin
                e = expected_beats.pop_front();
                if (kind !== e.kind) report_mismatch("kind", 64'(kind), 64'(e.kind));
                if (channel !== e.channel)
                    report_mismatch("channel", 64'(channel), 64'(e.channel));
                if (sample_bits !== e.sample_bits)
                    report_mismatch("sample_bits", 64'(sample_bits), 64'(e.sample_bits));
                if (trigger_bits !== e.trigger_bits)
                    report_mismatch("trigger_bits", 64'(trigger_bits),
                                    64'(e.trigger_bits));
                if (time_bits !== e.time_bits)
                    report_mismatch("time_bits", 64'(time_bits), 64'(e.time_bits));
                if (adc_status !== e.adc_status)
                    report_mismatch("adc_status", 64'(adc_status), 64'(e.adc_status));
                if (first_after_start !== e.first_after_start)
                    report_mismatch("first_after_start", 64'(first_after_start),
                                    64'(e.first_after_start));
                if (evt_code !== e.evt_code)
                    report_mismatch("evt_code", 64'(evt_code), 64'(e.evt_code));
                if (last !== e.last) report_mismatch("last", 64'(last), 64'(e.last));
            end
        end
    end

    // Receiver stall: random, or held for a long stretch when requested.
    always @(posedge clk)
    begin
        if (hold_off_cycles > 0)
        begin
            out_stall <= 1'b1;
            hold_off_cycles <= hold_off_cycles - 1;
        end
        else if (stall_random_on)
            out_stall <= ($urandom_range(0, 19) == 0) ? 1'b1 :
                         ($urandom_range(0, 3) == 0);
        else
            out_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 400000)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ---------------- tests ----------------
    // Start event, then a short sample packet: first flag set, missing sources zero.
    task automatic test_start_and_missing_sources();
        send_event(epdr_pkg::EV_CODE_START, 0, 1);
        send_sample(5, good_time(), 1);
        go_idle();
    endtask

    // Timestamp just below the threshold is dropped.
    task automatic test_time_threshold();
        send_sample(1, {1'b0, min_time_reg - 31'd1}, 1);
        go_idle();
    endtask

    // Receiver holds off while short event packets keep arriving.
    task automatic test_backpressure();
        hold_off_cycles = 200;
        send_event(epdr_pkg::EV_CODE_A, 0, 0);
        send_event(epdr_pkg::EV_CODE_B, 0, 0);
        send_event(epdr_pkg::EV_CODE_C, 0, 0);
        send_event(epdr_pkg::EV_CODE_STOP, 0, 0);
        go_idle();
    endtask

    // New token and zero threshold: a zero timestamp is accepted.
    task automatic test_config();
        write_reg(epdr_pkg::CFG_SYNC_TOKEN, {$urandom, 8'($urandom)});
        write_reg(epdr_pkg::CFG_MIN_TIME, 40'd0);
        send_sample(1, 32'h0000_0000, 1);
        go_idle();
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        byte_in = '0;
        out_stall = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = 1'b0;
        cfg_data = '0;
        error_count = 0;
        cycle_count = 0;
        hold_off_cycles = 0;
        stall_random_on = 1'b0;
        tok_reg = epdr_pkg::SYNC_TOKEN_RST;
        min_time_reg = epdr_pkg::MIN_TIME_RST;
        win = '0;
        phase = PH_HUNT;
        cnt = 0;
        ptype = '0;
        plen = '0;
        ts_word = '0;
        status_w = '0;
        asm_word = '0;
        trig_word = '0;
        mode = epdr_pkg::MODE_INITIAL;
        foreach (chan_words[i]) chan_words[i] = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        stall_random_on = 1'b1;
        test_start_and_missing_sources();
        test_time_threshold();
        test_backpressure();
        test_config();

        go_idle();
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
